[rtl/nfha_pkg.sv]
// ----------------------------------------------------------------------------
// nfha_pkg
// Word types and request and status codes of the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

    localparam int CFG_W = 17;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_BADPTR   = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] block_address;
        logic [15:0] request_bytes;
    } req_t;

    typedef struct packed {
        logic [15:0] result_address;
        logic [1:0]  status;
        logic        moved;
        logic [15:0] copy_bytes;
    } rsp_t;

endpackage

[rtl/nfha_ram.sv]
// ----------------------------------------------------------------------------
// nfha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nfha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/next_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// An allocate search makes one header read of the metadata RAM per block
// visited, and a resize whose block moves runs an allocate plus a free.
// One request is in flight at a time; the result waits in an output register
// and the allocator is ready for the next request once the result is loaded.
// Reset and every arena_bytes write run a clearing pass over every unit of
// the configured arena, during which no request is accepted.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator #(
    parameter int ARENA_UNITS     = 8192,
    parameter int ALIGN_BYTES     = 8,
    parameter int HEADER_UNITS    = 4,
    parameter int SPLIT_MIN_UNITS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  nfha_pkg::req_t       req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output nfha_pkg::rsp_t       rsp_data,
    input  logic                 cfg_we,
    input  logic [nfha_pkg::CFG_W-1:0] cfg_data
);
    import nfha_pkg::*;

    localparam int BW  = $clog2(ARENA_UNITS + 1);
    localparam int AW  = $clog2(ARENA_UNITS);
    localparam int CW  = ((BW > 16) ? BW : 16) + 2;
    localparam int SH  = $clog2(ALIGN_BYTES);
    localparam int ADW = BW + 2;
    localparam int AU_RAW   = 65536 / ALIGN_BYTES;
    localparam int AU_LO    = (AU_RAW < HEADER_UNITS) ? HEADER_UNITS : AU_RAW;
    localparam int AU_RESET = (AU_LO > ARENA_UNITS) ? ARENA_UNITS : AU_LO;
    localparam logic [BW-1:0] TERM = BW'(ARENA_UNITS);
    localparam logic [CW-1:0] SPLIT_EXTRA = CW'(HEADER_UNITS + SPLIT_MIN_UNITS);

    typedef enum logic [23:0] {
        S_CLEAR    = 24'h000001,
        S_IDLE     = 24'h000002,
        S_DECODE   = 24'h000004,
        S_LOC      = 24'h000008,
        S_FR_LD    = 24'h000010,
        S_FR_LD2   = 24'h000020,
        S_FR_START = 24'h000040,
        S_FR_PREV  = 24'h000080,
        S_FR_CLRP  = 24'h000100,
        S_FR_NRD   = 24'h000200,
        S_FR_NEXT  = 24'h000400,
        S_FR_CLRN  = 24'h000800,
        S_AL_START = 24'h001000,
        S_AL_ROV   = 24'h002000,
        S_AL_RD    = 24'h004000,
        S_AL_CHK   = 24'h008000,
        S_AL_SPL   = 24'h010000,
        S_RS_N     = 24'h020000,
        S_RS_S1    = 24'h040000,
        S_RS_S2    = 24'h080000,
        S_RS_G1    = 24'h100000,
        S_RS_G2    = 24'h200000,
        S_RS_GN    = 24'h400000,
        S_DONE     = 24'h800000
    } state_t;

    function automatic logic [BW-1:0] follow_f(
        input logic [BW-1:0] h,
        input logic [BW-1:0] u,
        input logic [BW-1:0] au
    );
        logic [BW:0] e;
        e = {1'b0, h} + {1'b0, u};
        if (h >= au)
        begin
            return '0;
        end
        if (e >= {1'b0, au} || e <= {1'b0, h})
        begin
            return TERM;
        end
        return e[BW-1:0];
    endfunction

    function automatic logic [15:0] user_addr_f(input logic [BW-1:0] g);
        logic [31:0] t;
        t = (32'(g) + 32'(HEADER_UNITS)) << SH;
        return t[15:0];
    endfunction

    state_t          state_reg;
    logic [BW-1:0]   clr_reg;
    logic [BW-1:0]   au_reg;
    logic [BW-1:0]   rover_reg;
    logic [1:0]      kind_reg;
    logic [15:0]     addr_reg;
    logic [15:0]     bytes_reg;
    logic [CW-1:0]   need_reg;
    logic [BW-1:0]   p_reg;
    logic [BW-1:0]   pu_reg;
    logic [BW-1:0]   pprior_reg;
    logic [BW-1:0]   oldp_reg;
    logic [BW-1:0]   n_reg;
    logic            ntaken_reg;
    logic [BW-1:0]   nn_reg;
    logic [BW-1:0]   s_reg;
    logic [BW-1:0]   sval_reg;
    logic [BW-1:0]   q_reg;
    logic [BW:0]     guard_reg;
    logic            move_reg;
    logic [15:0]     res_reg;
    logic [1:0]      st_reg;
    logic            moved_reg;
    logic [15:0]     copy_reg;
    logic            out_valid_reg;
    rsp_t            out_reg;

    logic            a_we;
    logic [AW-1:0]   a_waddr;
    logic [ADW-1:0]  a_wdata;
    logic [ADW-1:0]  a_rdata;
    logic            b_we;
    logic [AW-1:0]   b_waddr;
    logic [BW-1:0]   b_wdata;
    logic [BW-1:0]   b_rdata;
    logic [AW-1:0]   rd_addr;

    logic [BW-1:0]   a_units;
    logic            a_taken;
    logic            a_mark;
    logic [CW-1:0]   need_c;
    logic [15:0]     loc_u;
    logic            loc_ok;
    logic [BW-1:0]   loc_h;
    logic [BW-1:0]   fol_rov;
    logic [BW-1:0]   fol_q;
    logic [BW-1:0]   fol_pa;
    logic [BW-1:0]   fol_p;
    logic [BW-1:0]   fol_n;
    logic            prev_taken;
    logic            n_taken_c;
    logic [BW-1:0]   nu_c;
    logic [CW-1:0]   pu_w;
    logic            fit_c;
    logic            split_c;
    logic [BW-1:0]   s_al;
    logic            rs_fits;
    logic            rs_shrink;
    logic [CW-1:0]   total_c;
    logic [31:0]     cfg_u;
    logic [BW-1:0]   au_cfg;
    logic [31:0]     old_user;
    logic            out_load;

    assign a_units = a_rdata[ADW-1:2];
    assign a_taken = a_rdata[1];
    assign a_mark  = a_rdata[0];

    assign need_c = CW'(HEADER_UNITS)
                  + CW'((32'(req_data.request_bytes) + 32'(ALIGN_BYTES - 1)) >> SH);

    assign loc_u  = addr_reg >> SH;
    assign loc_ok = ((addr_reg & 16'(ALIGN_BYTES - 1)) == 16'd0)
                 && (32'(loc_u) >= 32'(HEADER_UNITS))
                 && ((32'(loc_u) - 32'(HEADER_UNITS)) < 32'(au_reg));
    assign loc_h  = BW'(32'(loc_u) - 32'(HEADER_UNITS));

    assign fol_rov = follow_f(rover_reg, a_units, au_reg);
    assign fol_q   = follow_f(q_reg, a_units, au_reg);
    assign fol_pa  = follow_f(p_reg, a_units, au_reg);
    assign fol_p   = follow_f(p_reg, pu_reg, au_reg);
    assign fol_n   = follow_f(n_reg, a_units, au_reg);

    assign prev_taken = (pprior_reg >= au_reg) || a_taken;
    assign n_taken_c  = (n_reg >= au_reg) || a_taken;
    assign nu_c       = (n_reg >= au_reg) ? '0 : a_units;
    assign pu_w       = CW'(pu_reg);

    assign fit_c   = (q_reg < au_reg) && !a_taken && (CW'(a_units) >= need_reg);
    assign split_c = CW'(a_units) >= need_reg + SPLIT_EXTRA;
    assign s_al    = BW'(CW'(q_reg) + need_reg);

    assign rs_fits   = pu_w >= need_reg;
    assign rs_shrink = (pu_w >= (need_reg << 1)) && (need_reg >= SPLIT_EXTRA);
    assign total_c   = pu_w + CW'(nu_c);

    assign cfg_u  = 32'(cfg_data) >> SH;
    assign au_cfg = (cfg_u > 32'(ARENA_UNITS))  ? BW'(ARENA_UNITS) :
                    (cfg_u < 32'(HEADER_UNITS)) ? BW'(HEADER_UNITS) : BW'(cfg_u);

    assign old_user = (32'(pu_reg) - 32'(HEADER_UNITS)) << SH;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp_ready) && !cfg_we;

    nfha_ram #(
        .WIDTH (ADW),
        .DEPTH (ARENA_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    nfha_ram #(
        .WIDTH (BW),
        .DEPTH (ARENA_UNITS)
    ) u_prior_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        rd_addr = '0;
        a_we    = 1'b0;
        a_waddr = '0;
        a_wdata = '0;
        b_we    = 1'b0;
        b_waddr = '0;
        b_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg[AW-1:0];
                a_wdata = (clr_reg == '0) ? {au_reg, 2'b01} : '0;
                b_we    = (clr_reg == '0);
                b_wdata = TERM;
            end
            S_DECODE:   rd_addr = loc_h[AW-1:0];
            S_LOC:      rd_addr = fol_pa[AW-1:0];
            S_FR_LD:    rd_addr = p_reg[AW-1:0];
            S_FR_START:
            begin
                a_we    = 1'b1;
                a_waddr = p_reg[AW-1:0];
                a_wdata = {pu_reg, 2'b01};
                rd_addr = pprior_reg[AW-1:0];
            end
            S_FR_PREV:
            begin
                if (!prev_taken)
                begin
                    a_we    = 1'b1;
                    a_waddr = pprior_reg[AW-1:0];
                    a_wdata = {BW'(pu_w + CW'(a_units)), 2'b01};
                    b_we    = fol_p < au_reg;
                    b_waddr = fol_p[AW-1:0];
                    b_wdata = pprior_reg;
                end
            end
            S_FR_CLRP:
            begin
                a_we    = 1'b1;
                a_waddr = oldp_reg[AW-1:0];
            end
            S_FR_NRD:   rd_addr = fol_p[AW-1:0];
            S_FR_NEXT:
            begin
                if (!n_taken_c)
                begin
                    a_we    = 1'b1;
                    a_waddr = p_reg[AW-1:0];
                    a_wdata = {BW'(pu_w + CW'(a_units)), 2'b01};
                    b_we    = fol_n < au_reg;
                    b_waddr = fol_n[AW-1:0];
                    b_wdata = p_reg;
                end
            end
            S_FR_CLRN:
            begin
                a_we    = 1'b1;
                a_waddr = n_reg[AW-1:0];
            end
            S_AL_START: rd_addr = rover_reg[AW-1:0];
            S_AL_RD:    rd_addr = q_reg[AW-1:0];
            S_AL_CHK:
            begin
                if (fit_c && split_c)
                begin
                    a_we    = 1'b1;
                    a_waddr = s_al[AW-1:0];
                    a_wdata = {BW'(CW'(a_units) - need_reg), 2'b01};
                    b_we    = 1'b1;
                    b_waddr = s_al[AW-1:0];
                    b_wdata = q_reg;
                end
                else if (fit_c)
                begin
                    a_we    = 1'b1;
                    a_waddr = q_reg[AW-1:0];
                    a_wdata = {a_units, 1'b1, a_mark};
                end
            end
            S_AL_SPL:
            begin
                a_we    = 1'b1;
                a_waddr = q_reg[AW-1:0];
                a_wdata = {BW'(need_reg), 2'b11};
                b_we    = n_reg < au_reg;
                b_waddr = n_reg[AW-1:0];
                b_wdata = s_reg;
            end
            S_RS_N:
            begin
                if (!rs_fits && !n_taken_c && total_c >= need_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = n_reg[AW-1:0];
                end
            end
            S_RS_S1, S_RS_G1:
            begin
                a_we    = 1'b1;
                a_waddr = s_reg[AW-1:0];
                a_wdata = {sval_reg, 2'b01};
                b_we    = 1'b1;
                b_waddr = s_reg[AW-1:0];
                b_wdata = p_reg;
            end
            S_RS_S2:
            begin
                if (ntaken_reg)
                begin
                    a_we    = 1'b1;
                    a_waddr = p_reg[AW-1:0];
                    a_wdata = {BW'(need_reg), 2'b11};
                    b_we    = n_reg < au_reg;
                    b_waddr = n_reg[AW-1:0];
                    b_wdata = s_reg;
                end
                else
                begin
                    a_we    = 1'b1;
                    a_waddr = n_reg[AW-1:0];
                    b_we    = nn_reg < au_reg;
                    b_waddr = nn_reg[AW-1:0];
                    b_wdata = s_reg;
                end
            end
            S_RS_G2:
            begin
                a_we    = 1'b1;
                a_waddr = p_reg[AW-1:0];
                a_wdata = {BW'(need_reg), 2'b11};
                b_we    = nn_reg < au_reg;
                b_waddr = nn_reg[AW-1:0];
                b_wdata = s_reg;
            end
            S_RS_GN:
            begin
                a_we    = 1'b1;
                a_waddr = p_reg[AW-1:0];
                a_wdata = {sval_reg, 2'b11};
                b_we    = nn_reg < au_reg;
                b_waddr = nn_reg[AW-1:0];
                b_wdata = p_reg;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            au_reg        <= BW'(AU_RESET);
            rover_reg     <= TERM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                au_reg    <= au_cfg;
                clr_reg   <= '0;
                rover_reg <= TERM;
                state_reg <= S_CLEAR;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == au_reg - 1'b1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (req_valid)
                        begin
                            kind_reg  <= req_data.req_type;
                            addr_reg  <= req_data.block_address;
                            bytes_reg <= req_data.request_bytes;
                            need_reg  <= need_c;
                            res_reg   <= '0;
                            st_reg    <= ST_OK;
                            moved_reg <= 1'b0;
                            copy_reg  <= '0;
                            state_reg <= S_DECODE;
                        end
                    end
                    S_DECODE:
                    begin
                        if (kind_reg == REQ_ALLOC
                            || (kind_reg == REQ_RESIZE && addr_reg == '0))
                        begin
                            move_reg  <= 1'b0;
                            state_reg <= S_AL_START;
                        end
                        else if (kind_reg == REQ_FREE && addr_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if ((kind_reg != REQ_FREE && kind_reg != REQ_RESIZE) || !loc_ok)
                        begin
                            st_reg    <= ST_BADPTR;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            p_reg     <= loc_h;
                            state_reg <= S_LOC;
                        end
                    end
                    S_LOC:
                    begin
                        pu_reg     <= a_units;
                        pprior_reg <= b_rdata;
                        n_reg      <= fol_pa;
                        if (!a_mark || !a_taken)
                        begin
                            st_reg    <= ST_BADPTR;
                            state_reg <= S_DONE;
                        end
                        else if (kind_reg == REQ_FREE)
                        begin
                            state_reg <= S_FR_START;
                        end
                        else if (bytes_reg == '0)
                        begin
                            st_reg    <= ST_RELEASED;
                            state_reg <= S_FR_START;
                        end
                        else
                        begin
                            state_reg <= S_RS_N;
                        end
                    end
                    S_FR_LD:    state_reg <= S_FR_LD2;
                    S_FR_LD2:
                    begin
                        pu_reg     <= a_units;
                        pprior_reg <= b_rdata;
                        state_reg  <= S_FR_START;
                    end
                    S_FR_START:
                    begin
                        if (rover_reg == p_reg)
                        begin
                            rover_reg <= pprior_reg;
                        end
                        state_reg <= S_FR_PREV;
                    end
                    S_FR_PREV:
                    begin
                        if (!prev_taken)
                        begin
                            oldp_reg   <= p_reg;
                            p_reg      <= pprior_reg;
                            pu_reg     <= BW'(pu_w + CW'(a_units));
                            pprior_reg <= b_rdata;
                            if (rover_reg == pprior_reg)
                            begin
                                rover_reg <= b_rdata;
                            end
                            state_reg <= S_FR_CLRP;
                        end
                        else
                        begin
                            state_reg <= S_FR_NRD;
                        end
                    end
                    S_FR_CLRP:  state_reg <= S_FR_NRD;
                    S_FR_NRD:
                    begin
                        n_reg     <= fol_p;
                        state_reg <= S_FR_NEXT;
                    end
                    S_FR_NEXT:
                    begin
                        state_reg <= n_taken_c ? S_DONE : S_FR_CLRN;
                    end
                    S_FR_CLRN:  state_reg <= S_DONE;
                    S_AL_START:
                    begin
                        guard_reg <= '0;
                        if (rover_reg >= au_reg)
                        begin
                            q_reg     <= '0;
                            state_reg <= S_AL_RD;
                        end
                        else
                        begin
                            state_reg <= S_AL_ROV;
                        end
                    end
                    S_AL_ROV:
                    begin
                        q_reg     <= fol_rov;
                        state_reg <= S_AL_RD;
                    end
                    S_AL_RD:
                    begin
                        if (q_reg == rover_reg || guard_reg > (BW + 1)'(ARENA_UNITS + 1))
                        begin
                            st_reg    <= ST_NOSPACE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            guard_reg <= guard_reg + 1'b1;
                            state_reg <= S_AL_CHK;
                        end
                    end
                    S_AL_CHK:
                    begin
                        if (fit_c)
                        begin
                            rover_reg <= q_reg;
                            res_reg   <= user_addr_f(q_reg);
                            if (move_reg)
                            begin
                                moved_reg <= 1'b1;
                                copy_reg  <= old_user[15:0];
                            end
                            if (split_c)
                            begin
                                s_reg     <= s_al;
                                n_reg     <= fol_q;
                                state_reg <= S_AL_SPL;
                            end
                            else
                            begin
                                state_reg <= move_reg ? S_FR_LD : S_DONE;
                            end
                        end
                        else
                        begin
                            q_reg     <= fol_q;
                            state_reg <= S_AL_RD;
                        end
                    end
                    S_AL_SPL:   state_reg <= move_reg ? S_FR_LD : S_DONE;
                    S_RS_N:
                    begin
                        ntaken_reg <= n_taken_c;
                        nn_reg     <= fol_n;
                        s_reg      <= BW'(pu_w + CW'(p_reg) - pu_w + need_reg);
                        if (rs_fits)
                        begin
                            res_reg <= addr_reg;
                            if (rs_shrink)
                            begin
                                sval_reg <= n_taken_c ? BW'(pu_w - need_reg)
                                                      : BW'(total_c - need_reg);
                                if (!n_taken_c && rover_reg == n_reg)
                                begin
                                    rover_reg <= fol_n;
                                end
                                state_reg <= S_RS_S1;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else if (n_taken_c || total_c < need_reg)
                        begin
                            move_reg  <= 1'b1;
                            state_reg <= S_AL_START;
                        end
                        else
                        begin
                            res_reg <= addr_reg;
                            if (rover_reg == n_reg)
                            begin
                                rover_reg <= fol_n;
                            end
                            if (total_c >= need_reg + SPLIT_EXTRA)
                            begin
                                sval_reg  <= BW'(total_c - need_reg);
                                state_reg <= S_RS_G1;
                            end
                            else
                            begin
                                sval_reg  <= BW'(total_c);
                                state_reg <= S_RS_GN;
                            end
                        end
                    end
                    S_RS_S1:    state_reg <= S_RS_S2;
                    S_RS_S2:    state_reg <= ntaken_reg ? S_DONE : S_RS_G2;
                    S_RS_G1:    state_reg <= S_RS_G2;
                    S_RS_G2:    state_reg <= S_DONE;
                    S_RS_GN:    state_reg <= S_DONE;
                    S_DONE:
                    begin
                        if (out_load)
                        begin
                            out_reg.result_address <= (st_reg == ST_OK) ? res_reg : '0;
                            out_reg.status         <= st_reg;
                            out_reg.moved          <= moved_reg;
                            out_reg.copy_bytes     <= copy_reg;
                            state_reg              <= S_IDLE;
                        end
                    end
                    default:    state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    a_rover_range: assert property (@(posedge clk) disable iff (!rst_n)
        rover_reg == TERM || rover_reg < au_reg)
        else $error("rover outside arena");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> state_reg == S_CLEAR)
        else $error("config write did not start clearing pass");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (!out_valid_reg || rsp_ready) |=> rsp_valid)
        else $error("finished word not presented");

endmodule
